@@ design/diagonal_sobel_edge_filter_defines.svh @@
// Assertion macros shared by the diagonal Sobel edge filter.
`ifndef DIAGONAL_SOBEL_EDGE_FILTER_DEFINES_SVH
`define DIAGONAL_SOBEL_EDGE_FILTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DSEF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DSEF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dsef_pkg.sv @@
// Types and constants of the diagonal Sobel edge filter.
`timescale 1ns / 1ps
package dsef_pkg;

    localparam int PIX_W      = 8;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 12;
    localparam int ROW_W      = 13;
    localparam int SUM_W      = 12;
    localparam int ABS_W      = 10;
    localparam int KSUM_W     = 4;
    localparam int DIV_W      = 3;
    localparam int RECIP3     = 683;
    localparam int RECIP3_SH  = 11;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef logic signed [2:0] coef_t;

    // Row-major, row 0 = line above, column 0 = left.
    localparam coef_t K45 [9]  = '{3'sd0, -3'sd1, -3'sd2,
                                   3'sd1, 3'sd0, -3'sd1,
                                   3'sd2, 3'sd1, 3'sd0};
    localparam coef_t K135 [9] = '{-3'sd2, -3'sd1, 3'sd0,
                                   -3'sd1, 3'sd0, 3'sd1,
                                   3'sd0, 3'sd1, 3'sd2};

    typedef struct packed {
        logic take;
        logic shift;
        logic calc;
        logic load;
    } dsef_cmd_t;

    typedef struct packed {
        logic pixels_due;
        logic pad_item;
        logic emit;
        logic out_free;
    } dsef_status_t;

endpackage

@@ design/dsef_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dsef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ design/dsef_ctrl.sv @@
// Sequencer of the edge filter: take, line-store update, sums, divide and output.
`timescale 1ns / 1ps
module dsef_ctrl
    import dsef_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output dsef_cmd_t    cmd,
    input  dsef_status_t status
);
    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC, ST_DIV} state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                // drop a pad while pixels are still due
                if (s_tvalid && !(status.pixels_due && status.pad_item)) begin
                    cmd.take   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.shift  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!status.emit) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

@@ design/dsef_datapath.sv @@
// Datapath of the edge filter: counters, line stores, window, sums, divide, output register.
`timescale 1ns / 1ps
module dsef_datapath
    import dsef_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dsef_cmd_t               cmd,
    output dsef_status_t            status,
    input  logic [7:0]              s_tdata,
    input  logic [0:0]              s_tuser,
    input  logic                    cfg_valid,
    input  logic [0:0]              cfg_index,
    input  logic [HEIGHT_CFG_W-1:0] cfg_data,
    output logic [7:0]              m_tdata,
    output logic                    m_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic [CW-1:0]           in_col_reg;
    logic [ROW_W-1:0]        in_row_reg;
    logic [CW-1:0]           col_reg;
    logic [PIX_W-1:0]        cur_reg;
    logic                    emit_reg, top_reg, bot_reg, left_reg, right_reg, last_reg;
    logic [PIX_W-1:0]        win_reg [3][3];
    logic [ABS_W-1:0]        abs_a_reg, abs_b_reg;
    logic [DIV_W-1:0]        div_a_reg, div_b_reg;
    logic [PIX_W-1:0]        out_data_reg;
    logic                    out_last_reg, out_valid_reg;

    logic [WW-1:0]           eff_w;
    logic [ROW_W-1:0]        eff_h;
    logic                    col0;
    logic [PIX_W-1:0]        up_data, mid_data;
    logic                    restart;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(width_reg);
        end
        eff_h = (height_reg == '0) ? ROW_W'(1) : ROW_W'(height_reg);
    end

    assign col0    = (in_col_reg == '0);
    assign restart = (cfg_valid) || (cmd.load && last_reg);

    assign status.pixels_due = (in_row_reg < eff_h);
    assign status.pad_item   = s_tuser[0];
    assign status.emit       = emit_reg;
    assign status.out_free   = !out_valid_reg || m_tready;

    // configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            in_col_reg <= '0;
            in_row_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_IDX_WIDTH:  width_reg  <= cfg_data[WIDTH_CFG_W-1:0];
                    CFG_IDX_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (restart) begin
                in_col_reg <= '0;
                in_row_reg <= '0;
            end else if (cmd.take) begin
                if (WW'(in_col_reg) + WW'(1) >= eff_w) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + ROW_W'(1);
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
        end
    end

    // latch the item and the border flags of its result position
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            col_reg   <= in_col_reg;
            cur_reg   <= status.pixels_due ? s_tdata : '0;
            emit_reg  <= (in_row_reg >= ROW_W'(2)) || (in_row_reg == ROW_W'(1) && !col0);
            top_reg   <= col0 ? (in_row_reg >= ROW_W'(3)) : (in_row_reg >= ROW_W'(2));
            bot_reg   <= col0 ? (in_row_reg <= eff_h) : (in_row_reg < eff_h);
            left_reg  <= col0 ? (eff_w >= WW'(2)) : (in_col_reg >= CW'(2));
            right_reg <= !col0;
            last_reg  <= col0 && (in_row_reg == eff_h + ROW_W'(1));
        end
    end

    dsef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk(aclk), .we(cmd.shift), .waddr(col_reg), .wdata(mid_data),
        .re(cmd.take), .raddr(in_col_reg), .rdata(up_data)
    );

    dsef_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .aclk(aclk), .we(cmd.shift), .waddr(col_reg), .wdata(cur_reg),
        .re(cmd.take), .raddr(in_col_reg), .rdata(mid_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= up_data;
            win_reg[1][2] <= mid_data;
            win_reg[2][2] <= cur_reg;
        end
    end

    // masked kernel sums
    logic signed [SUM_W-1:0]  sum_a, sum_b;
    logic signed [KSUM_W-1:0] ks_a, ks_b;
    logic [2:0]               row_ok, col_ok;

    always_comb begin
        logic signed [SUM_W-1:0] px;
        row_ok = {bot_reg, 1'b1, top_reg};
        col_ok = {right_reg, 1'b1, left_reg};
        sum_a  = '0;
        sum_b  = '0;
        ks_a   = '0;
        ks_b   = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                px = $signed({{(SUM_W-PIX_W){1'b0}}, win_reg[r][c]});
                if (row_ok[r] && col_ok[c]) begin
                    sum_a = sum_a + px * SUM_W'(K45[r*3+c]);
                    sum_b = sum_b + px * SUM_W'(K135[r*3+c]);
                    ks_a  = ks_a + KSUM_W'(K45[r*3+c]);
                    ks_b  = ks_b + KSUM_W'(K135[r*3+c]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            abs_a_reg <= ABS_W'(sum_a < 0 ? -sum_a : sum_a);
            abs_b_reg <= ABS_W'(sum_b < 0 ? -sum_b : sum_b);
            div_a_reg <= DIV_W'(ks_a < 0 ? -ks_a : ks_a);
            div_b_reg <= DIV_W'(ks_b < 0 ? -ks_b : ks_b);
        end
    end

    // divide by a weight magnitude of 0..4
    function automatic logic [ABS_W-1:0] div_small(input logic [ABS_W-1:0] x,
                                                   input logic [DIV_W-1:0] d);
        logic [ABS_W+RECIP3_SH-1:0] prod;
        prod = (ABS_W+RECIP3_SH)'(x) * (ABS_W+RECIP3_SH)'(RECIP3);
        case (d)
            3'd2:    div_small = x >> 1;
            3'd3:    div_small = ABS_W'(prod >> RECIP3_SH);
            3'd4:    div_small = x >> 2;
            default: div_small = x;
        endcase
    endfunction

    logic [ABS_W:0] edge_sum;
    logic [ABS_W-1:0] edge_half;
    assign edge_sum  = {1'b0, div_small(abs_a_reg, div_a_reg)}
                     + {1'b0, div_small(abs_b_reg, div_b_reg)};
    assign edge_half = edge_sum[ABS_W:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_data_reg <= (edge_half > ABS_W'(255)) ? 8'd255 : edge_half[PIX_W-1:0];
            out_last_reg <= last_reg;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;
endmodule

@@ design/diagonal_sobel_edge_filter.sv @@
// Top level of the diagonal Sobel edge filter.
`timescale 1ns / 1ps
//  channel | direction | carries
//  s_*     | in        | tdata: pixel_value[7:0]; tuser: is_pad
//  m_*     | out       | tdata: edge_value[7:0]; tlast: frame_last
//  cfg_*   | in        | index 0 image_width, 1 image_height; data 12 bits
//
//  An accepted item goes through take and line-store read, store update and window
//  shift, kernel sums, divide and output load, as the registered line-store read and
//  the two arithmetic stages need; no new item is taken until it is through.
//  A pad that arrives while pixels are still due is accepted and dropped.
//  A result waits in the output register; the last stage holds while it is full.
//  Synchronous active-low reset; line stores need no clearing pass.
`include "diagonal_sobel_edge_filter_defines.svh"
module diagonal_sobel_edge_filter
    import dsef_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_value
    input  logic [0:0]  s_tuser,   // [0] is_pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] edge_value
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    dsef_cmd_t    cmd;
    dsef_status_t status;

    // register writes are always taken; they restart the frame at once
    assign cfg_ready = 1'b1;

    dsef_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .cmd(cmd), .status(status)
    );

    dsef_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    `DSEF_ASSERT_NOW(a_cmd_onehot, aclk, aresetn, 1'b1, $onehot0(cmd), "overlapping commands")
    `DSEF_ASSERT_NEXT(a_take_then_shift, aclk, aresetn, cmd.take, cmd.shift, "shift missing")
    `DSEF_ASSERT_NOW(a_load_free, aclk, aresetn, cmd.load, status.out_free, "result overwritten")
    `DSEF_ASSERT_NOW(a_busy_no_take, aclk, aresetn, !s_tready, !cmd.take, "take while busy")
endmodule

@@ tb/diagonal_sobel_edge_filter_tb.sv @@
// Self-checking testbench of the diagonal Sobel edge filter.
`timescale 1ns / 1ps
module diagonal_sobel_edge_filter_tb;
    import dsef_pkg::*;

    localparam int LINE_DEPTH = 1024;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_TARGET = 680;

    typedef struct {
        logic [7:0] pixel;
        logic       pad;
    } pixel_item_t;

    typedef struct {
        logic [7:0] edge_val;
        logic       last;
    } edge_item_t;

    typedef struct {
        logic [0:0]  idx;
        logic [11:0] data;
    } reg_write_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] pixel_value
    logic [0:0]  s_tuser = '0;   // [0] is_pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] edge_value
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    pixel_item_t pixels_pending[$];
    edge_item_t  edges_expected[$];
    reg_write_t  reg_writes[$];

    // Shadow state of the filter
    logic [7:0]  upper_line [LINE_DEPTH];
    logic [7:0]  middle_line [LINE_DEPTH];
    logic [7:0]  win [9];
    int          col_in, row_in;
    logic [10:0] width_reg;
    logic [11:0] height_reg;

    int  error_count = 0;
    int  edges_seen = 0;
    int  frames_seen = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  hold_sender = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  random_items = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    diagonal_sobel_edge_filter DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    // Normalised absolute diagonal sum over the taps inside the image
    function automatic int diag_strength(input bit is135, input int oy, input int ox,
                                         input int w, input int h);
        int k45 [9]  = '{0, -1, -2, 1, 0, -1, 2, 1, 0};
        int k135 [9] = '{-2, -1, 0, -1, 0, 1, 0, 1, 2};
        int sum, ksum, kv, y, x;
        sum = 0;
        ksum = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                y = oy + dy;
                x = ox + dx;
                if (y >= 0 && y < h && x >= 0 && x < w) begin
                    kv = is135 ? k135[(dy+1)*3 + dx+1] : k45[(dy+1)*3 + dx+1];
                    sum += int'(win[(dy+1)*3 + dx+1]) * kv;
                    ksum += kv;
                end
            end
        end
        if (ksum != 0) sum = sum / ksum;
        return (sum < 0) ? -sum : sum;
    endfunction

    function automatic void restart_frame();
        col_in = 0;
        row_in = 0;
    endfunction

    // Advance the shadow state by one accepted item; queue any edge it yields
    function automatic void filter_step(input pixel_item_t it);
        int w, h, c, oy, ox, a, b, e;
        logic [7:0] cur, up, mid;
        bit emit;
        edge_item_t res;
        w = eff_width();
        h = eff_height();
        cur = '0;
        if (row_in < h) begin
            if (it.pad) return;    // pad while pixels still due: drop
            cur = it.pixel;
        end
        c = (col_in >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_in;
        up = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = cur;
        for (int r = 0; r < 3; r++) begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = cur;
        emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
        if (col_in >= 1) begin
            oy = row_in - 1;
            ox = col_in - 1;
        end else begin
            oy = row_in - 2;
            ox = w - 1;
        end
        col_in++;
        if (col_in >= w) begin
            col_in = 0;
            row_in++;
        end
        if (!emit) return;
        a = diag_strength(1'b0, oy, ox, w, h);
        b = diag_strength(1'b1, oy, ox, w, h);
        e = (a + b) / 2;
        if (e > 255) e = 255;
        res.edge_val = e[7:0];
        res.last = (oy == h - 1 && ox == w - 1);
        if (res.last) restart_frame();
        edges_expected.push_back(res);
    endfunction

    // Input driver: bursts with random gaps, held while hold_sender is set
    always @(posedge aclk) begin
        bit accepted, drive;
        accepted = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (accepted) begin
                filter_step(pixels_pending.pop_front());
                items_sent++;
            end
            drive = 1'b0;
            if (s_tvalid && !accepted) begin
                drive = 1'b1;                      // hold until taken
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pixels_pending.size() > 0 && !hold_sender) begin
                drive = 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 48);
                    // long gapless stretches now and then
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
                burst_left--;
            end
            s_tvalid <= drive;
            if (drive) begin
                s_tdata <= pixels_pending[0].pixel;
                s_tuser <= pixels_pending[0].pad;
            end
        end
    end

    // Result monitor with its own stall pattern
    always @(posedge aclk) begin
        edge_item_t exp_item;
        int mode;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                edges_seen++;
                if (m_tlast) frames_seen++;
                if (edges_expected.size() == 0) begin
                    $display("%0t: unexpected edge %0d last %0b", $time, m_tdata, m_tlast);
                    error_count++;
                end else begin
                    exp_item = edges_expected.pop_front();
                    if (m_tdata !== exp_item.edge_val) begin
                        $display("%0t: edge_value expected %0d actual %0d",
                                 $time, exp_item.edge_val, m_tdata);
                        error_count++;
                    end
                    if (m_tlast !== exp_item.last) begin
                        $display("%0t: frame_last expected %0b actual %0b",
                                 $time, exp_item.last, m_tlast);
                        error_count++;
                    end
                end
            end
            mode = (cycle_count / 300) % 4;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 5) == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Register writes; the shadow restarts its frame on each
    always @(posedge aclk) begin
        bit drive;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            drive = 1'b0;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IDX_WIDTH) width_reg = cfg_data[10:0];
                else height_reg = cfg_data;
                restart_frame();
                void'(reg_writes.pop_front());
            end
            if (reg_writes.size() > 0) begin
                drive = 1'b1;
                cfg_index <= reg_writes[0].idx;
                cfg_data <= reg_writes[0].data;
            end
            cfg_valid <= drive;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("diagonal_sobel_edge_filter_tb: errors");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pixels_pending.size() != 0 || edges_expected.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_geometry(input int w, input int h);
        reg_write_t wr;
        wait_idle();
        wr.idx = CFG_IDX_WIDTH;
        wr.data = 12'(w);
        reg_writes.push_back(wr);
        wr.idx = CFG_IDX_HEIGHT;
        wr.data = 12'(h);
        reg_writes.push_back(wr);
        while (reg_writes.size() != 0 || cfg_valid) @(posedge aclk);
    endtask

    task automatic push_item(input logic [7:0] pix, input logic pad);
        pixel_item_t it;
        it.pixel = pix;
        it.pad = pad;
        pixels_pending.push_back(it);
    endtask

    // Queue one frame; style 0 random, 1 extremes, 2 checkerboard.
    // Cut short a frame when 'cut' is nonzero (stops after that many pixels).
    task automatic queue_frame(input int w, input int h, input int style,
                               input int pad_pct, input int cut);
        int n;
        logic [7:0] p;
        n = w * h;
        for (int i = 0; i < n; i++) begin
            if (cut != 0 && i >= cut) return;
            if ($urandom_range(0, 99) < pad_pct) push_item(8'($urandom), 1'b1);
            case (style)
                1: p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                2: p = (((i % w) + (i / w)) % 2) ? 8'hFF : 8'h00;
                default: p = 8'($urandom);
            endcase
            push_item(p, 1'b0);
            random_items++;
        end
        // tail flush: pads or pixels, either drives it out
        for (int i = 0; i <= w; i++) push_item(8'($urandom), 1'($urandom_range(0, 1)));
        random_items += w + 1;
    endtask

    initial begin
        int w, h, frames;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        restart_frame();
        for (int i = 0; i < 9; i++) win[i] = '0;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: checkerboard 3x3 with pads inside, then 1x1 via zero sizes
        set_geometry(3, 3);
        queue_frame(3, 3, 2, 30, 0);
        set_geometry(0, 0);
        queue_frame(1, 1, 1, 50, 0);
        queue_frame(1, 1, 1, 0, 0);
        set_geometry(2, 2);
        push_item(8'hFF, 1'b0);
        push_item(8'h00, 1'b1);
        push_item(8'h00, 1'b0);      // abandoned frame, restarted by the write
        random_items = 0;

        // Random geometries, mostly small, one to four frames each
        while (random_items < RANDOM_TARGET) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
            h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
            set_geometry(w, h);
            if (w == 0) w = 1;
            if (h == 0) h = 1;
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++)
                queue_frame(w, h, $urandom_range(0, 2), $urandom_range(0, 20), 0);
            if ($urandom_range(0, 3) == 0) begin
                // halt the sender until all results are in
                hold_sender = 1'b1;
                while (edges_expected.size() != 0 || s_tvalid) @(posedge aclk);
                hold_sender = 1'b0;
            end
            if ($urandom_range(0, 7) == 0)
                queue_frame(w, h, 0, 10, $urandom_range(1, w * h));
        end

        // Extremes of both registers, as partial frames restarted by the next write
        set_geometry(2047, 2);
        queue_frame(LINE_DEPTH, 2, 0, 1, LINE_DEPTH + 16);
        set_geometry(1, 4095);
        queue_frame(1, 4095, 1, 1, 24);
        wait_idle();

        $display("sent %0d items over many frame geometries, checked %0d edges in %0d frames",
                 items_sent, edges_seen, frames_seen);
        if (error_count == 0) begin
            $display("diagonal_sobel_edge_filter_tb: clean");
        end else begin
            $display("diagonal_sobel_edge_filter_tb: errors");
        end
        $finish;
    end

endmodule
